[rtl/sbcc_pkg.sv]
// Shared types and constants of the self-balancing cascade controller.
`default_nettype none

package sbcc_pkg;

	// Shared multiply-accumulate unit widths.
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 44;

	// Configuration register indexes.
	localparam logic [2:0] REG_BALANCE_KP   = 3'd0;
	localparam logic [2:0] REG_BALANCE_KI   = 3'd1;
	localparam logic [2:0] REG_BALANCE_KD   = 3'd2;
	localparam logic [2:0] REG_VELOCITY_KP  = 3'd3;
	localparam logic [2:0] REG_VELOCITY_KI  = 3'd4;
	localparam logic [2:0] REG_TARGET_SPEED = 3'd5;
	localparam logic [2:0] REG_UPRIGHT      = 3'd6;

	// Control of one multiply request to the shared unit.
	typedef struct packed {
		logic issue;
		logic clr;
		logic sh8;
	} mac_ctl_t;

endpackage

`default_nettype wire

[rtl/self_balancing_cascade_controller.sv]
// Top level of the self-balancing cascade controller: sequencer, state and I/O.
//
// One request on the input channel (in_valid/in_ready) carries one control tick:
// pitch, gyro rate, vertical acceleration, both encoder counts, direction and halt.
// One request on the output channel (out_valid/out_ready) returns drive, tilt_stop
// and lifted for that tick. Gains and set points are written on the cfg port, by
// the user only while the block is idle; the block does not enforce this. Writes
// take effect at once. A tick with the motors running steps from ST_BIAS to ST_FIN:
// seven products go one per cycle through the single 26x16 multiplier of sbcc_mac,
// and the speed filter result must settle before the velocity products start.
// A tick stopped by tilt or halt goes from ST_BIAS straight to ST_FIN. The result
// register is loaded in the last cycle, so in_ready rises while a result may still
// wait on out_ready.
// If the receiver stalls, a new tick is taken but its result waits in the final
// step until the output register is free.
// Reset clears the integrals, the speed filter, the pick-up detector and the
// output; gains reset to zero and target_speed to 50.
`default_nettype none

module self_balancing_cascade_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [16:0] pitch,
	input  wire logic signed [15:0] gyro_rate,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] left_count,
	input  wire logic signed [15:0] right_count,
	input  wire logic [1:0]         direction,
	input  wire logic               halt,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      drive,
	output logic                    tilt_stop,
	output logic                    lifted
);

	localparam int MAW = sbcc_pkg::MUL_A_W;
	localparam int MBW = sbcc_pkg::MUL_B_W;
	localparam int AW  = sbcc_pkg::ACC_W;

	localparam logic signed [17:0] TILT_LIMIT   = 18'sd20480;
	localparam logic signed [17:0] PITCH_OFFSET = 18'sd1024;
	localparam logic signed [17:0] LIFT_WINDOW  = 18'sd5120;
	localparam logic signed [15:0] LIFT_ACCEL   = 16'sd26000;
	localparam logic [17:0]        REST_LIMIT   = 18'd30;
	localparam logic [17:0]        SPIN_LIMIT   = 18'd200;
	localparam logic [7:0]         REST_TICKS   = 8'd10;
	localparam logic [7:0]         LIFT_TIMEOUT = 8'd200;
	localparam logic [7:0]         SPIN_TIMEOUT = 8'd100;
	localparam logic signed [MBW-1:0] FILT_OLD  = 16'sd179;
	localparam logic signed [MBW-1:0] FILT_NEW  = 16'sd77;
	localparam logic signed [27:0] INTEG_LIMIT  = 28'sd1843200;
	localparam logic signed [AW-1:0] FILT_MAX   = 44'sd33554431;
	localparam logic signed [AW-1:0] FILT_ROUND = 44'sd128;

	typedef enum logic [3:0] {
		ST_IDLE, ST_BIAS, ST_M1, ST_M2, ST_M3, ST_M4, ST_W1,
		ST_SF, ST_SI, ST_M6, ST_W2, ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PH_REST, PH_LIFT, PH_SPIN
	} phase_t;

	state_t state_q;

	// Configuration registers.
	logic signed [15:0] bkp_q, bki_q, bkd_q, vkp_q, vki_q;
	logic [7:0]         ts_q;
	logic signed [13:0] ua_q;

	// Controller state.
	logic signed [21:0] bi_q;
	logic signed [25:0] sf_q;
	logic signed [21:0] si_q;
	phase_t             phase_q;
	logic [7:0]         rest_q, lift_q, spin_q;

	// Latched tick and intermediate results.
	logic signed [16:0] pitch_q;
	logic signed [15:0] gyro_q, accel_q, left_q, right_q;
	logic [1:0]         dir_q;
	logic               halt_q;
	logic signed [27:0] bal_q;
	logic               stop_q, hit_q;

	// Output register.
	logic               out_valid_q;
	logic signed [15:0] drive_q;
	logic               tilt_stop_q, lifted_q;

	// Shared unit.
	sbcc_pkg::mac_ctl_t     mac_ctl;
	logic signed [MAW-1:0]  mac_a;
	logic signed [MBW-1:0]  mac_b;
	logic signed [AW-1:0]   acc;

	// Combinational helpers.
	logic signed [17:0] pitch18, bias, ua18;
	logic               run_ok;
	logic signed [22:0] bi_sum;
	logic signed [21:0] bi_next;
	logic signed [16:0] enc_sum;
	logic [16:0]        abs_l, abs_r;
	logic [17:0]        abs_sum;
	logic               still, lift_cond, spin_cond;
	phase_t             ph;
	logic [7:0]         rc, lc, sc;
	logic               lift_hit;
	logic signed [AW-1:0] sf_sh;
	logic signed [25:0] sf_next;
	logic signed [27:0] move, si_sum;
	logic signed [21:0] si_next;
	logic signed [27:0] vel;
	logic signed [28:0] drive_sum;
	logic signed [15:0] drive_sat;
	logic               out_free;

	function automatic logic [16:0] abs16(input logic signed [15:0] v);
		logic signed [16:0] e;
		e = 17'(v);
		return e[16] ? 17'(-e) : 17'(e);
	endfunction

	function automatic logic [17:0] abs17(input logic signed [16:0] v);
		logic signed [17:0] e;
		e = 18'(v);
		return e[17] ? 18'(-e) : 18'(e);
	endfunction

	// Integer part of a Q28.16 sum, truncated toward zero.
	function automatic logic signed [27:0] trunc16(input logic signed [AW-1:0] v);
		logic signed [27:0] q;
		q = v[AW-1:16];
		if (v[AW-1] && (v[15:0] != 16'd0)) begin
			q = q + 28'sd1;
		end
		return q;
	endfunction

	// Balance error and tilt window.
	assign pitch18 = 18'(pitch_q);
	assign bias    = pitch18 + PITCH_OFFSET;
	assign run_ok  = (pitch18 < TILT_LIMIT) && (pitch18 > -TILT_LIMIT) && !halt_q;

	// Clamped balance integral.
	always_comb begin
		bi_sum = 23'(bi_q) + 23'(bias);
		if (bi_sum > 23'(INTEG_LIMIT)) begin
			bi_next = 22'(INTEG_LIMIT);
		end else if (bi_sum < -23'(INTEG_LIMIT)) begin
			bi_next = 22'(-INTEG_LIMIT);
		end else begin
			bi_next = 22'(bi_sum);
		end
	end

	// Pick-up detector conditions.
	assign enc_sum   = 17'(left_q) + 17'(right_q);
	assign abs_l     = abs16(left_q);
	assign abs_r     = abs16(right_q);
	assign abs_sum   = 18'(abs_l) + 18'(abs_r);
	assign still     = abs_sum < REST_LIMIT;
	assign ua18      = 18'(ua_q);
	assign lift_cond = (accel_q > LIFT_ACCEL) && (pitch18 > ua18 - LIFT_WINDOW) &&
		(pitch18 < ua18 + LIFT_WINDOW);
	assign spin_cond = abs17(enc_sum) > SPIN_LIMIT;

	// Pick-up phases; several may pass in one tick.
	always_comb begin
		ph       = phase_q;
		rc       = rest_q;
		lc       = lift_q;
		sc       = spin_q;
		lift_hit = 1'b0;
		if (ph == PH_REST) begin
			if (still) begin
				rc = (rc != 8'hFF) ? rc + 8'd1 : rc;
			end else begin
				rc = 8'd0;
			end
			if (rc > REST_TICKS) begin
				ph = PH_LIFT;
				rc = 8'd0;
			end
		end
		if (ph == PH_LIFT) begin
			lc = lc + 8'd1;
			if (lc > LIFT_TIMEOUT) begin
				lc = 8'd0;
				ph = PH_REST;
			end
			if (lift_cond) begin
				ph = PH_SPIN;
			end
		end
		if (ph == PH_SPIN) begin
			sc = sc + 8'd1;
			if (sc > SPIN_TIMEOUT) begin
				sc = 8'd0;
				ph = PH_REST;
			end
			if (spin_cond) begin
				ph       = PH_REST;
				lift_hit = 1'b1;
			end
		end
	end

	// Speed filter update: round half up, then clamp.
	always_comb begin
		sf_sh = (acc + FILT_ROUND) >>> 8;
		if (sf_sh > FILT_MAX) begin
			sf_next = 26'(FILT_MAX);
		end else if (sf_sh < -FILT_MAX) begin
			sf_next = 26'(-FILT_MAX);
		end else begin
			sf_next = 26'(sf_sh);
		end
	end

	// Commanded movement and clamped speed integral.
	always_comb begin
		case (dir_q)
			2'd1: begin
				move = -28'($signed({1'b0, ts_q, 8'h00}));
			end
			2'd2: begin
				move = 28'($signed({1'b0, ts_q, 8'h00}));
			end
			default: begin
				move = 28'sd0;
			end
		endcase
		si_sum = 28'(si_q) + 28'(sf_q) - move;
		if (si_sum > INTEG_LIMIT) begin
			si_next = 22'(INTEG_LIMIT);
		end else if (si_sum < -INTEG_LIMIT) begin
			si_next = 22'(-INTEG_LIMIT);
		end else begin
			si_next = 22'(si_sum);
		end
	end

	// Final drive: both loops added and saturated.
	always_comb begin
		vel       = trunc16(acc);
		drive_sum = 29'(bal_q) + 29'(vel);
		if (drive_sum > 29'sd32767) begin
			drive_sat = 16'sd32767;
		end else if (drive_sum < -29'sd32768) begin
			drive_sat = -16'sd32768;
		end else begin
			drive_sat = 16'(drive_sum);
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			ST_BIAS: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b1, sh8: 1'b0};
				mac_a   = MAW'(bias);
				mac_b   = bkp_q;
			end
			ST_M1: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b0, sh8: 1'b0};
				mac_a   = MAW'(bi_q);
				mac_b   = bki_q;
			end
			ST_M2: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b0, sh8: 1'b1};
				mac_a   = MAW'(gyro_q);
				mac_b   = bkd_q;
			end
			ST_M3: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b1, sh8: 1'b0};
				mac_a   = sf_q;
				mac_b   = FILT_OLD;
			end
			ST_M4: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b0, sh8: 1'b1};
				mac_a   = MAW'(enc_sum);
				mac_b   = FILT_NEW;
			end
			ST_SI: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b1, sh8: 1'b0};
				mac_a   = sf_q;
				mac_b   = vkp_q;
			end
			ST_M6: begin
				mac_ctl = '{issue: 1'b1, clr: 1'b0, sh8: 1'b0};
				mac_a   = MAW'(si_q);
				mac_b   = vki_q;
			end
			default: begin
				mac_ctl = '0;
			end
		endcase
	end

	sbcc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (acc)
	);

	assign out_free = !out_valid_q || out_ready;

	// Latch the accepted tick and the balance loop result.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pitch_q <= pitch;
			gyro_q  <= gyro_rate;
			accel_q <= accel_z;
			left_q  <= left_count;
			right_q <= right_count;
			dir_q   <= direction;
			halt_q  <= halt;
		end
		if (state_q == ST_M4) begin
			bal_q <= trunc16(acc);
		end
	end

	// Sequencer, configuration, controller state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bkp_q       <= '0;
			bki_q       <= '0;
			bkd_q       <= '0;
			vkp_q       <= '0;
			vki_q       <= '0;
			ts_q        <= 8'd50;
			ua_q        <= '0;
			bi_q        <= '0;
			sf_q        <= '0;
			si_q        <= '0;
			phase_q     <= PH_REST;
			rest_q      <= '0;
			lift_q      <= '0;
			spin_q      <= '0;
			stop_q      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
			tilt_stop_q <= 1'b0;
			lifted_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					sbcc_pkg::REG_BALANCE_KP:   bkp_q <= cfg_data;
					sbcc_pkg::REG_BALANCE_KI:   bki_q <= cfg_data;
					sbcc_pkg::REG_BALANCE_KD:   bkd_q <= cfg_data;
					sbcc_pkg::REG_VELOCITY_KP:  vkp_q <= cfg_data;
					sbcc_pkg::REG_VELOCITY_KI:  vki_q <= cfg_data;
					sbcc_pkg::REG_TARGET_SPEED: ts_q  <= cfg_data[7:0];
					sbcc_pkg::REG_UPRIGHT:      ua_q  <= cfg_data[13:0];
					default: begin
					end
				endcase
			end

			// The final step reloads the output register itself.
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BIAS;
					end
				end
				ST_BIAS: begin
					// Tilt and halt checks, balance integral, pick-up step.
					stop_q <= !run_ok;
					if (run_ok) begin
						bi_q    <= bi_next;
						phase_q <= ph;
						rest_q  <= rc;
						lift_q  <= lc;
						spin_q  <= sc;
						hit_q   <= lift_hit;
						state_q <= ST_M1;
					end else begin
						bi_q    <= '0;
						si_q    <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_W1;
				ST_W1: state_q <= ST_SF;
				ST_SF: begin
					sf_q    <= sf_next;
					state_q <= ST_SI;
				end
				ST_SI: begin
					si_q    <= si_next;
					state_q <= ST_M6;
				end
				ST_M6: state_q <= ST_W2;
				ST_W2: state_q <= ST_FIN;
				ST_FIN: begin
					// Wait here until the output register is free.
					if (out_free) begin
						out_valid_q <= 1'b1;
						drive_q     <= (stop_q || hit_q) ? 16'sd0 : drive_sat;
						tilt_stop_q <= stop_q;
						lifted_q    <= hit_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign tilt_stop = tilt_stop_q;
	assign lifted    = lifted_q;

`ifndef SYNTHESIS
	// A tick keeps the block busy: in_ready is low in the cycle after the accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("block ready right after accepting a tick");

	// A stopped tick drives zero and never reports pick-up.
	a_stop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tilt_stop) |-> (drive == 16'sd0) && !lifted)
		else $error("tilt stop result with nonzero drive or lifted");

	// A detected pick-up forces zero drive.
	a_lift_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && lifted) |-> (drive == 16'sd0))
		else $error("lifted result with nonzero drive");

	// Both integrals stay inside their clamp.
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(28'(bi_q) <= INTEG_LIMIT) && (28'(bi_q) >= -INTEG_LIMIT) &&
		(28'(si_q) <= INTEG_LIMIT) && (28'(si_q) >= -INTEG_LIMIT))
		else $error("integral outside its clamp");
`endif

endmodule

`default_nettype wire

[rtl/sbcc_mac.sv]
// Shared signed multiplier with a registered product and a shifting accumulator.
`default_nettype none

module sbcc_mac (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire sbcc_pkg::mac_ctl_t                      ctl,
	input  wire logic signed [sbcc_pkg::MUL_A_W-1:0]     a,
	input  wire logic signed [sbcc_pkg::MUL_B_W-1:0]     b,
	output logic signed [sbcc_pkg::ACC_W-1:0]            acc
);

	localparam int PW = sbcc_pkg::PROD_W;
	localparam int AW = sbcc_pkg::ACC_W;

	sbcc_pkg::mac_ctl_t       ctl_s1;
	logic signed [PW-1:0]     prod_d;
	logic signed [PW-1:0]     prod_s1;
	logic signed [AW-1:0]     addend;
	logic signed [AW-1:0]     acc_q;

	// Product of the current request.
	assign prod_d = a * b;

	// Stage one: register the product and its control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_d;
	end

	// Stage two: optionally scale by 256, then load or add into the accumulator.
	always_comb begin
		if (ctl_s1.sh8) begin
			addend = AW'(prod_s1) <<< 8;
		end else begin
			addend = AW'(prod_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			if (ctl_s1.clr) begin
				acc_q <= addend;
			end else begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
